// ===== src/bcad_pkg.sv =====
// Shared constants and types for the button combo action detector.
`default_nettype none

package bcad_pkg;

    // Default build sizes
    localparam int NUM_ACTIONS_DEF = 4;
    localparam int KEY_BITS_DEF    = 32;

    // Fixed port widths
    localparam int KEY_W     = 32;
    localparam int FLAG_W    = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    // Combination mode of one action
    typedef enum logic [1:0] {
        MODE_ALL   = 2'd0,
        MODE_ANY   = 2'd1,
        MODE_ONE   = 2'd2,
        MODE_NEVER = 2'd3
    } mode_t;

    // Per-action evaluation status
    typedef struct packed {
        logic active;
        logic armed;
    } act_status_t;

endpackage : bcad_pkg

`default_nettype wire

// ===== src/button_combo_action_detector_core.sv =====
// Top level of the button combo action detector: key edges and action flags.
// A result beat appears the cycle after its input beat is accepted.
// Throughput: one beat per cycle while not stalled, set by the single result register stage.
// in_stall rises only while a held result is stalled downstream.
// Reset clears previous keys, previous action flags, config and out_valid.
// Result payload registers are not reset.
`default_nettype none

module button_combo_action_detector_core #(
    parameter int NUM_ACTIONS = bcad_pkg::NUM_ACTIONS_DEF,
    parameter int KEY_BITS    = bcad_pkg::KEY_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [bcad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcad_pkg::CFG_DAT_W-1:0] cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [bcad_pkg::KEY_W-1:0]     keys_now,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [bcad_pkg::KEY_W-1:0]     keys_pressed,
    output logic      [bcad_pkg::KEY_W-1:0]     keys_held,
    output logic      [bcad_pkg::KEY_W-1:0]     keys_released,
    output logic      [bcad_pkg::FLAG_W-1:0]    action_active,
    output logic      [bcad_pkg::FLAG_W-1:0]    action_triggered,
    output logic      [bcad_pkg::FLAG_W-1:0]    action_ended
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [KEY_BITS-1:0]      masks [NUM_ACTIONS];
    logic [2*NUM_ACTIONS-1:0] modes;

    bcad_cfg_regs #(
        .NUM_ACTIONS (NUM_ACTIONS),
        .KEY_BITS    (KEY_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .masks     (masks),
        .modes     (modes)
    );

    // ------------------------------------------------------------------
    // Handshake: take a beat whenever the result register is free or
    // is being drained this cycle.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    assign in_stall       = out_valid_reg && out_stall;
    assign accept         = in_valid && !in_stall;
    assign out_valid_next = accept || (out_valid_reg && out_stall);

    // ------------------------------------------------------------------
    // Per-frame evaluation; only the low KEY_BITS keys take part.
    // ------------------------------------------------------------------
    logic [KEY_BITS-1:0]    keys;
    logic [KEY_BITS-1:0]    prev_keys_reg;
    logic [NUM_ACTIONS-1:0] prev_active_reg;
    logic [NUM_ACTIONS-1:0] active;
    logic [NUM_ACTIONS-1:0] armed;
    logic [NUM_ACTIONS-1:0] triggered;
    logic [NUM_ACTIONS-1:0] ended;

    assign keys = keys_now[KEY_BITS-1:0];

    for (genvar a = 0; a < NUM_ACTIONS; a++)
    begin : g_action
        bcad_pkg::act_status_t status;

        bcad_action_eval #(
            .KEY_BITS (KEY_BITS)
        ) u_eval (
            .keys   (keys),
            .mask   (masks[a]),
            .mode   (modes[2*a +: 2]),
            .status (status)
        );

        assign active[a] = status.active;
        assign armed[a]  = status.armed;
    end

    // An action whose mask was emptied is disarmed, and the end check is
    // gated by the armed flag, so it reports no end.
    assign triggered = active & ~prev_active_reg;
    assign ended     = prev_active_reg & ~active & armed;

    // ------------------------------------------------------------------
    // State: advance only on an accepted beat; valid follows the handshake.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            prev_keys_reg   <= '0;
            prev_active_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                prev_keys_reg   <= keys;
                prev_active_reg <= active;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on accept, hold while stalled.
    // ------------------------------------------------------------------
    logic [bcad_pkg::KEY_W-1:0]  pressed_reg;
    logic [bcad_pkg::KEY_W-1:0]  held_reg;
    logic [bcad_pkg::KEY_W-1:0]  released_reg;
    logic [bcad_pkg::FLAG_W-1:0] active_reg;
    logic [bcad_pkg::FLAG_W-1:0] trig_reg;
    logic [bcad_pkg::FLAG_W-1:0] ended_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pressed_reg  <= bcad_pkg::KEY_W'(keys & ~prev_keys_reg);
            held_reg     <= bcad_pkg::KEY_W'(keys);
            released_reg <= bcad_pkg::KEY_W'(prev_keys_reg & ~keys);
            active_reg   <= bcad_pkg::FLAG_W'(active);
            trig_reg     <= bcad_pkg::FLAG_W'(triggered);
            ended_reg    <= bcad_pkg::FLAG_W'(ended);
        end
    end

    assign out_valid        = out_valid_reg;
    assign keys_pressed     = pressed_reg;
    assign keys_held        = held_reg;
    assign keys_released    = released_reg;
    assign action_active    = active_reg;
    assign action_triggered = trig_reg;
    assign action_ended     = ended_reg;

endmodule : button_combo_action_detector_core

`default_nettype wire

// ===== src/bcad_cfg_regs.sv =====
// Configuration register file: action key masks and action modes.
`default_nettype none

module bcad_cfg_regs #(
    parameter int NUM_ACTIONS = bcad_pkg::NUM_ACTIONS_DEF,
    parameter int KEY_BITS    = bcad_pkg::KEY_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bcad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcad_pkg::CFG_DAT_W-1:0] cfg_data,
    output logic      [KEY_BITS-1:0]            masks [NUM_ACTIONS],
    output logic      [2*NUM_ACTIONS-1:0]       modes
);

    logic [KEY_BITS-1:0]      mask_reg [NUM_ACTIONS];
    logic [2*NUM_ACTIONS-1:0] modes_reg;

    // Indexes past the mode register fall through and are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_ACTIONS; a++)
            begin
                mask_reg[a] <= '0;
            end
            modes_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            for (int a = 0; a < NUM_ACTIONS; a++)
            begin
                if (cfg_index == bcad_pkg::CFG_IDX_W'(a))
                begin
                    mask_reg[a] <= cfg_data[KEY_BITS-1:0];
                end
            end
            if (cfg_index == bcad_pkg::CFG_IDX_W'(NUM_ACTIONS))
            begin
                modes_reg <= cfg_data[2*NUM_ACTIONS-1:0];
            end
        end
    end

    assign masks = mask_reg;
    assign modes = modes_reg;

endmodule : bcad_cfg_regs

`default_nettype wire

// ===== src/bcad_action_eval.sv =====
// Combination check of one action against the current key bitmap.
`default_nettype none

module bcad_action_eval #(
    parameter int KEY_BITS = bcad_pkg::KEY_BITS_DEF
) (
    input  wire logic [KEY_BITS-1:0]   keys,
    input  wire logic [KEY_BITS-1:0]   mask,
    input  wire logic [1:0]            mode,
    output bcad_pkg::act_status_t      status
);

    logic [KEY_BITS-1:0] hit;
    logic                all_held;
    logic                any_held;
    logic                one_held;
    logic                on;

    // Exactly one: nonzero and clearing the lowest set bit leaves nothing.
    assign hit      = keys & mask;
    assign all_held = (hit == mask);
    assign any_held = |hit;
    assign one_held = any_held && ((hit & (hit - KEY_BITS'(1))) == '0);

    always_comb
    begin
        unique case (bcad_pkg::mode_t'(mode))
            bcad_pkg::MODE_ALL:   on = all_held;
            bcad_pkg::MODE_ANY:   on = any_held;
            bcad_pkg::MODE_ONE:   on = one_held;
            bcad_pkg::MODE_NEVER: on = 1'b0;
            default:              on = 1'b0;
        endcase
    end

    // An empty mask disarms the action entirely.
    assign status.armed  = |mask;
    assign status.active = status.armed && on;

endmodule : bcad_action_eval

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the button combo action detector core.

module testbench;

    // Clock and run control
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int TAIL_CYCLES  = 4;     // slack after the last drain
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RUN_LIMIT    = 2000000;
    localparam int MAX_REPORTS  = 10;

    // Stimulus sizes
    localparam int NUM_ACT      = bcad_pkg::NUM_ACTIONS_DEF;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_FRAMES = 105;

    // Register map of the configuration port
    localparam logic [bcad_pkg::CFG_IDX_W-1:0] REG_MASK0 = 4'd0;
    localparam logic [bcad_pkg::CFG_IDX_W-1:0] REG_MODES = 4'd4;
    localparam logic [bcad_pkg::CFG_IDX_W-1:0] REG_TOP   = 4'd15;

    // One result beat as the block reports it
    typedef struct packed {
        logic [bcad_pkg::KEY_W-1:0]  pressed;
        logic [bcad_pkg::KEY_W-1:0]  held;
        logic [bcad_pkg::KEY_W-1:0]  released;
        logic [bcad_pkg::FLAG_W-1:0] active;
        logic [bcad_pkg::FLAG_W-1:0] triggered;
        logic [bcad_pkg::FLAG_W-1:0] ended;
    } frame_result_t;

    // DUT inputs, all known from time zero
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [bcad_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bcad_pkg::CFG_DAT_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic [bcad_pkg::KEY_W-1:0]     keys_now  = '0;
    logic                           out_stall = 1'b0;

    // DUT outputs
    wire                            in_stall;
    wire                            out_valid;
    wire [bcad_pkg::KEY_W-1:0]      keys_pressed;
    wire [bcad_pkg::KEY_W-1:0]      keys_held;
    wire [bcad_pkg::KEY_W-1:0]      keys_released;
    wire [bcad_pkg::FLAG_W-1:0]     action_active;
    wire [bcad_pkg::FLAG_W-1:0]     action_triggered;
    wire [bcad_pkg::FLAG_W-1:0]     action_ended;

    // Tracker of what the block should report: its config and frame history
    logic [bcad_pkg::KEY_W-1:0] combo_mask [NUM_ACT];
    logic [2*NUM_ACT-1:0]       combo_modes = '0;
    logic [bcad_pkg::KEY_W-1:0] last_keys   = '0;
    logic [NUM_ACT-1:0]         last_active = '0;
    frame_result_t              expected_frames [$];
    frame_result_t              oldest_frame;

    int error_count = 0;

    // Idle knobs, retuned per phase by the test tasks
    int gap_pct   = 0;
    int gap_max   = 1;
    int stall_pct = 0;
    int stall_max = 4;
    int stall_left = 0;
    logic stall_phase = 1'b0;

    button_combo_action_detector_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .keys_now         (keys_now),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .keys_pressed     (keys_pressed),
        .keys_held        (keys_held),
        .keys_released    (keys_released),
        .action_active    (action_active),
        .action_triggered (action_triggered),
        .action_ended     (action_ended)
    );

    always #CLK_HALF clk = ~clk;

    initial
    begin
        for (int a = 0; a < NUM_ACT; a++)
        begin
            combo_mask[a] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Tracker: work out the result beat of one accepted frame, queue it
    // and advance the frame history. An action with an empty mask is
    // forced inactive and its history is cleared, so it can never end.
    // ------------------------------------------------------------------
    task automatic advance_key_tracker(input logic [bcad_pkg::KEY_W-1:0] keys);
        frame_result_t      r;
        logic [NUM_ACT-1:0] on;
        logic [NUM_ACT-1:0] live;
        int                 total;
        int                 hits;
        bcad_pkg::mode_t    mode;
        on   = '0;
        live = '0;
        for (int a = 0; a < NUM_ACT; a++)
        begin
            total   = $countones(combo_mask[a]);
            hits    = $countones(combo_mask[a] & keys);
            mode    = bcad_pkg::mode_t'(combo_modes[2*a +: 2]);
            live[a] = (total != 0);
            if (live[a])
            begin
                case (mode)
                    bcad_pkg::MODE_ALL: on[a] = (hits == total);
                    bcad_pkg::MODE_ANY: on[a] = (hits > 0);
                    bcad_pkg::MODE_ONE: on[a] = (hits == 1);
                    default:            on[a] = 1'b0;
                endcase
            end
        end
        r.pressed   = keys & ~last_keys;
        r.held      = keys;
        r.released  = last_keys & ~keys;
        r.active    = on;
        r.triggered = on & ~(last_active & live);
        r.ended     = last_active & live & ~on;
        expected_frames.insert(expected_frames.size(), r);
        last_keys   = keys;
        last_active = on;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall in runs of random length; stall_pct sets how many
    // runs are stalled, so zero gives a stretch with no back-pressure.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left <= 0)
        begin
            stall_phase = ($urandom_range(99) < stall_pct);
            stall_left  = $urandom_range(1, stall_max);
        end
        stall_left--;
        out_stall <= stall_phase;
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted result beat with the oldest frame
    // that is still waiting. Values are sampled before this edge updates.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("[%0t] result beat with no frame pending: held=%h", $realtime,
                             keys_held);
            end
            else
            begin
                oldest_frame = expected_frames.pop_front();
                if (keys_pressed     !== oldest_frame.pressed  ||
                    keys_held        !== oldest_frame.held     ||
                    keys_released    !== oldest_frame.released ||
                    action_active    !== oldest_frame.active   ||
                    action_triggered !== oldest_frame.triggered ||
                    action_ended     !== oldest_frame.ended)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("[%0t] mismatch", $realtime);
                        $display("  expected pressed=%h held=%h released=%h act=%b trig=%b end=%b",
                                 oldest_frame.pressed, oldest_frame.held,
                                 oldest_frame.released, oldest_frame.active,
                                 oldest_frame.triggered, oldest_frame.ended);
                        $display("  actual   pressed=%h held=%h released=%h act=%b trig=%b end=%b",
                                 keys_pressed, keys_held, keys_released,
                                 action_active, action_triggered, action_ended);
                    end
                end
            end
        end
    end

    // Send one frame; return at the edge that accepts it. Valid stays up.
    task automatic send_frame(input logic [bcad_pkg::KEY_W-1:0] keys);
        in_valid <= 1'b1;
        keys_now <= keys;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_key_tracker(keys);
    endtask

    // Drop valid and wait until every queued frame has come back or DRAIN_LIMIT runs out.
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_frames.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Write one register; the tracker follows the block's decode.
    task automatic write_reg(input logic [bcad_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcad_pkg::CFG_DAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx < REG_MODES)
            combo_mask[idx[$clog2(NUM_ACT)-1:0]] = data;
        else if (idx == REG_MODES)
            combo_modes = data[2*NUM_ACT-1:0];
    endtask

    // Load a full setting while idle, plus one write to an unused index
    // that the block must ignore.
    task automatic program_config(input logic [NUM_ACT-1:0][bcad_pkg::KEY_W-1:0] masks,
                                  input logic [bcad_pkg::CFG_DAT_W-1:0] modes);
        drain_results();
        for (int a = 0; a < NUM_ACT; a++)
        begin
            write_reg(REG_MASK0 + bcad_pkg::CFG_IDX_W'(a), masks[a]);
        end
        write_reg(REG_MODES, modes);
        write_reg(bcad_pkg::CFG_IDX_W'($urandom_range(REG_MODES + 1, REG_TOP)), $urandom());
        cfg_wr_en <= 1'b0;
    endtask

    // One random key out of m, or any single key when m is empty.
    function automatic logic [bcad_pkg::KEY_W-1:0] pick_member(
        input logic [bcad_pkg::KEY_W-1:0] m);
        logic [bcad_pkg::KEY_W-1:0] one_hot;
        int                         start;
        int                         pos;
        one_hot = '0;
        start   = $urandom_range(bcad_pkg::KEY_W - 1);
        for (int i = 0; i < bcad_pkg::KEY_W; i++)
        begin
            pos = (start + i) % bcad_pkg::KEY_W;
            if (m[pos] || m == '0)
            begin
                one_hot[pos] = 1'b1;
                return one_hot;
            end
        end
        return one_hot;
    endfunction

    // Key bitmap aimed at one action's mask most of the time, so that the
    // all/any/exactly-one conditions and their edges are actually hit.
    function automatic logic [bcad_pkg::KEY_W-1:0] pick_keys();
        logic [bcad_pkg::KEY_W-1:0] m;
        m = combo_mask[$urandom_range(NUM_ACT - 1)];
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            4:       return m;
            5:       return m | ($urandom() & $urandom());
            6:       return m & $urandom();
            7:       return pick_member(m) | (~m & $urandom());
            8:       return last_keys ^ pick_member('0);
            default: return m & ~pick_member(m);
        endcase
    endfunction

    function automatic logic [bcad_pkg::KEY_W-1:0] rand_mask();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return pick_member('0);
            3:       return pick_member('0) | pick_member('0) | pick_member('0);
            4:       return $urandom() & $urandom() & $urandom();
            default: return $urandom();
        endcase
    endfunction

    // Stream frames in bursts of random length with random gaps between.
    task automatic send_stream(input int count);
        int burst;
        burst = $urandom_range(1, 16);
        repeat (count)
        begin
            send_frame(pick_keys());
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                if ($urandom_range(99) < gap_pct)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, gap_max))
                        @(posedge clk);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test: key edges with the reset setting. Every mask is empty, so all
    // action flags stay low while the key outputs swing across extremes.
    // ------------------------------------------------------------------
    task automatic test_key_edges();
        stall_pct = 30;
        send_frame(32'h0000_0000);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'h0000_0000);
        send_frame(32'hAAAA_AAAA);
        send_frame(32'h5555_5555);
        send_frame(32'h8000_0000);
        send_frame(32'h0000_0001);
    endtask

    // ------------------------------------------------------------------
    // Test: one action per mode. Junk above the mode field must be dropped.
    // Action 0 all held, 1 any held, 2 exactly one, 3 never.
    // ------------------------------------------------------------------
    task automatic test_combo_modes();
        program_config({32'h8000_0001, 32'h0000_0F00, 32'h0000_00F0, 32'h0000_000F},
                       {24'hA5A5A5, bcad_pkg::MODE_NEVER, bcad_pkg::MODE_ONE,
                        bcad_pkg::MODE_ANY, bcad_pkg::MODE_ALL});
        send_frame(32'h0000_0007);   // partial combo, nothing active
        send_frame(32'h0000_001F);   // all of action 0, one of action 1
        send_frame(32'h0000_0100);   // drop both, action 2 sees exactly one
        send_frame(32'h0000_0300);   // two keys end action 2
        send_frame(32'h8000_0FFF);   // never mode stays low with its keys held
        send_frame(32'hFFFF_FFFF);
    endtask

    // ------------------------------------------------------------------
    // Test: an active action ends when switched to never mode, and one whose
    // mask is cleared drops silently, then triggers again once restored.
    // ------------------------------------------------------------------
    task automatic test_never_and_empty();
        program_config({32'h8000_0001, 32'h0, 32'h0, 32'h0000_0001},
                       {24'h0, bcad_pkg::MODE_ANY, bcad_pkg::MODE_ALL,
                        bcad_pkg::MODE_ALL, bcad_pkg::MODE_ANY});
        send_frame(32'h8000_0001);   // actions 0 and 3 trigger
        program_config({32'h8000_0001, 32'h0, 32'h0, 32'h0000_0001},
                       {24'h0, bcad_pkg::MODE_NEVER, bcad_pkg::MODE_ALL,
                        bcad_pkg::MODE_ALL, bcad_pkg::MODE_ANY});
        send_frame(32'h8000_0001);   // action 3 ends
        program_config({32'h8000_0001, 32'h0, 32'h0, 32'h0},
                       {24'h0, bcad_pkg::MODE_NEVER, bcad_pkg::MODE_ALL,
                        bcad_pkg::MODE_ALL, bcad_pkg::MODE_ANY});
        send_frame(32'h8000_0001);   // action 0 emptied: no end flag
        program_config({32'h8000_0001, 32'h0, 32'h0, 32'h0000_0001},
                       {24'h0, bcad_pkg::MODE_NEVER, bcad_pkg::MODE_ALL,
                        bcad_pkg::MODE_ALL, bcad_pkg::MODE_ANY});
        send_frame(32'h8000_0001);   // action 0 triggers again
    endtask

    // ------------------------------------------------------------------
    // Test: random frames over several settings. The first phases pin the
    // extremes (all keys in every mask, all-held and never modes) with no
    // idling; the rest draw masks, modes and idle pressure at random.
    // ------------------------------------------------------------------
    task automatic test_random_frames();
        logic [NUM_ACT-1:0][bcad_pkg::KEY_W-1:0] masks;
        logic [bcad_pkg::CFG_DAT_W-1:0]          modes;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            for (int a = 0; a < NUM_ACT; a++)
            begin
                masks[a] = (p < 2) ? '1 : rand_mask();
            end
            case (p)
                0:       modes = '0;
                1:       modes = '1;
                default: modes = $urandom();
            endcase
            if (p < 2)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = $urandom_range(0, 80);
                gap_max   = $urandom_range(1, 8);
                stall_pct = $urandom_range(0, 70);
                stall_max = $urandom_range(1, 8);
            end
            program_config(masks, modes);
            send_stream(PHASE_FRAMES);
        end
    endtask

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #RUN_LIMIT;
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence: reset once, run each test, drain, report.
    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_edges();
        test_combo_modes();
        test_never_and_empty();
        test_random_frames();

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        error_count += expected_frames.size();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
